/* sv/cde_pkg.sv */
// ----------------------------------------------------------------------------
// cde_pkg
// Shared types, micro-program and constants for the convolution descriptor
// expander.
// ----------------------------------------------------------------------------
`default_nettype none

package cde_pkg;

  localparam int DIV_NW = 32;
  localparam int DIV_DW = 20;

  localparam int IMAGE_ALIGN       = 16;
  localparam int FILTER_ELEM_ALIGN = 16;

  typedef enum logic [5:0] {
    OP_OH_DIV, OP_OH_SET, OP_OW_DIV, OP_OW_SET,
    OP_CPG_DIV, OP_CPG_SET, OP_FPG_DIV, OP_FPG_SET,
    OP_IAPR_MUL, OP_IAPR_SET,
    OP_FAA_MUL1, OP_FAA_MUL2, OP_FAA_SET,
    OP_OAPR_MUL, OP_OAPR_SET,
    OP_SRCH_INIT, OP_X_MID, OP_P, OP_NEED, OP_EVAL, OP_LOOP,
    OP_WIN_FIX, OP_BNUM_DIV, OP_BNUM_SET, OP_BLAST_MUL, OP_BLAST_SET,
    OP_X_WIN, OP_NW_SAVE, OP_X_BLAST,
    OP_W8_MUL, OP_W8_MUL2, OP_W18_DIV, OP_W18_SET, OP_W19_DIV, OP_W19_SET,
    OP_W20, OP_W5, OP_W10, OP_END
  } op_e;

  typedef enum logic [4:0] {
    W_OH, W_OW, W_FPG, W_CPG, W_IAPR, W_IPAD, W_FAA, W_OAPR, W_IBLK, W_FPAD,
    W_WFIRST, W_WMULTI, W_BNUM, W_BLEN, W_BLEN_LAST, W_WIN, W_WIN_LAST,
    W_RES_ALIGN, W_PFULL, W_POST_PFULL, W_BIAS_LEN, W_CMD
  } word_e;

  localparam int PROG_LEN = 43;
  localparam logic [5:0] LOOP_TARGET = 6'd16;

  localparam op_e PROG [PROG_LEN] = '{
    OP_OH_DIV, OP_OH_SET, OP_OW_DIV, OP_OW_SET,
    OP_CPG_DIV, OP_CPG_SET, OP_FPG_DIV, OP_FPG_SET,
    OP_IAPR_MUL, OP_IAPR_SET,
    OP_FAA_MUL1, OP_FAA_MUL2, OP_FAA_SET,
    OP_OAPR_MUL, OP_OAPR_SET,
    OP_SRCH_INIT, OP_X_MID, OP_P, OP_NEED, OP_EVAL, OP_LOOP,
    OP_WIN_FIX, OP_BNUM_DIV, OP_BNUM_SET, OP_BLAST_MUL, OP_BLAST_SET,
    OP_X_WIN, OP_P, OP_NEED, OP_NW_SAVE,
    OP_X_BLAST, OP_P, OP_NEED,
    OP_W8_MUL, OP_W8_MUL2, OP_W18_DIV, OP_W18_SET, OP_W19_DIV, OP_W19_SET,
    OP_W20, OP_W5, OP_W10, OP_END
  };

  typedef struct packed {
    logic       capture;
    logic       exec;
    op_e        op;
    logic       load_out;
    logic [4:0] out_idx;
    logic       out_err;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic div_busy;
    logic div_done;
    logic lo_lt_hi;
  } stat_t;

  function automatic logic op_is_div(op_e op);
    return op == OP_OH_DIV || op == OP_OW_DIV || op == OP_CPG_DIV ||
           op == OP_FPG_DIV || op == OP_BNUM_DIV ||
           op == OP_W18_DIV || op == OP_W19_DIV;
  endfunction

endpackage

`default_nettype wire

/* sv/cde_div.sv */
// ----------------------------------------------------------------------------
// cde_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_div #(
  parameter int NW = 32,
  parameter int DW = 20
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int CW = $clog2(NW);

  logic [NW-1:0] q_q;
  logic [DW-1:0] r_q, d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   trial;
  logic          ge;

  assign trial  = {r_q, q_q[NW-1]};
  assign ge     = trial >= {1'b0, d_q};
  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == CW'(NW - 1));
  assign quo_o  = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      q_q <= {q_q[NW-2:0], ge};
      r_q <= ge ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/cde_dp.sv */
// ----------------------------------------------------------------------------
// cde_dp
// Datapath: layer fields, derived words, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_dp
  import cde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  input  wire logic [3:0]  kernel_width_i,
  input  wire logic [3:0]  kernel_height_i,
  input  wire logic [3:0]  stride_vertical_i,
  input  wire logic [3:0]  stride_horizontal_i,
  input  wire logic [12:0] channel_count_i,
  input  wire logic [12:0] image_height_i,
  input  wire logic [12:0] image_width_i,
  input  wire logic [3:0]  pad_vertical_i,
  input  wire logic [3:0]  pad_horizontal_i,
  input  wire logic [12:0] filter_count_i,
  input  wire logic [12:0] group_count_i,
  input  wire logic        relu_on_i,
  output logic [4:0]       word_index_o,
  output logic [63:0]      word_value_o,
  output logic             error_o,
  output logic             last_o
);

  logic [3:0]  kw_q, kh_q, sv_q, sh_q, pv_q, ph_q;
  logic [12:0] ch_q, ih_q, iw_q, fc_q, gc_q;
  logic        relu_q;

  logic [13:0] oh_q, ow_q, lo_q, hi_q, win_q, bnum_q, blast_q;
  logic [12:0] cpg_q, fpg_q;
  logic [31:0] m_q;
  logic [27:0] iapr_q, oapr_q, w5_q;
  logic [21:0] faa_q;
  logic [4:0]  w17_q;
  logic [17:0] x_q;
  logic [26:0] need_q, needw_q, w20_q;
  logic [30:0] w8_q;
  logic [16:0] w9_q;
  logic [63:0] w10_q, w18_q, w19_q;
  logic [33:0] w11_q;
  logic        dz_q;

  logic [4:0]  oidx_q;
  logic [63:0] oword_q;
  logic        oerr_q, olast_q;

  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;
  logic [31:0]       aln_a, aln_f;
  logic [13:0]       mid, win_fix, fpg_al;
  logic [16:0]       ph_ch;
  logic signed [7:0]  rdiff;
  logic signed [36:0] w10_p;
  logic [63:0]       word_sel;

  cde_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_n),
    .den_i  (div_d),
    .busy_o (div_busy),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  assign div_start = cmd_i.exec && op_is_div(cmd_i.op);
  assign aln_a = (m_q + 32'(IMAGE_ALIGN - 1)) / 32'(IMAGE_ALIGN) * 32'(IMAGE_ALIGN);
  assign aln_f = (m_q + 32'(FILTER_ELEM_ALIGN - 1)) / 32'(FILTER_ELEM_ALIGN) *
                 32'(FILTER_ELEM_ALIGN);
  assign mid   = 14'((15'(lo_q) + 15'(hi_q)) >> 1);
  assign fpg_al = (14'(fpg_q) + 14'd7) & ~14'd7;
  assign ph_ch = 17'(ph_q) * 17'(ch_q);
  assign rdiff = $signed({2'b00, sv_q, 2'b00}) - $signed({4'b0000, pv_q});
  assign w10_p = $signed({9'b0, iapr_q}) * 37'(rdiff);

  always_comb begin
    div_n = '0;
    div_d = '0;
    unique case (cmd_i.op)
      OP_OH_DIV: begin
        div_n = 32'(14'(ih_q) + {9'b0, pv_q, 1'b0} - 14'(kh_q));
        div_d = DIV_DW'(sv_q);
      end
      OP_OW_DIV: begin
        div_n = 32'(14'(iw_q) + {9'b0, ph_q, 1'b0} - 14'(kw_q));
        div_d = DIV_DW'(sh_q);
      end
      OP_CPG_DIV: begin
        div_n = 32'(ch_q);
        div_d = DIV_DW'(gc_q);
      end
      OP_FPG_DIV: begin
        div_n = 32'(fc_q);
        div_d = DIV_DW'(gc_q);
      end
      OP_BNUM_DIV: begin
        div_n = 32'(15'(ow_q) + 15'(win_q) - 15'd1);
        div_d = DIV_DW'(win_q);
      end
      OP_W18_DIV: begin
        div_n = 32'd2048;
        div_d = {1'b0, faa_q[21:4], 1'b0};
      end
      OP_W19_DIV: begin
        div_n = 32'd512;
        div_d = DIV_DW'({(14'(fc_q) + 14'd3) >> 2, 1'b0});
      end
      default: ;
    endcase
  end

  always_comb begin
    win_fix = lo_q;
    if (win_fix != ow_q) win_fix = win_fix - 14'd1;
    if (win_fix[0] && win_fix != 14'd1) win_fix = win_fix - 14'd1;
    if (win_fix == 14'd0) win_fix = 14'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kw_q <= kernel_width_i;      kh_q <= kernel_height_i;
      sv_q <= stride_vertical_i;   sh_q <= stride_horizontal_i;
      ch_q <= channel_count_i;     ih_q <= image_height_i;
      iw_q <= image_width_i;       pv_q <= pad_vertical_i;
      ph_q <= pad_horizontal_i;    fc_q <= filter_count_i;
      gc_q <= group_count_i;       relu_q <= relu_on_i;
    end
    if (div_start) dz_q <= (div_d == '0);
    if (cmd_i.exec) begin
      unique case (cmd_i.op)
        OP_OH_SET:    oh_q <= dz_q ? 14'd0 : 14'(div_q) + 14'd1;
        OP_OW_SET:    ow_q <= dz_q ? 14'd0 : 14'(div_q) + 14'd1;
        OP_CPG_SET:   cpg_q <= 13'(div_q);
        OP_FPG_SET:   fpg_q <= 13'(div_q);
        OP_IAPR_MUL:  m_q <= 32'(iw_q) * 32'(ch_q);
        OP_IAPR_SET:  iapr_q <= 28'(aln_a);
        OP_FAA_MUL1:  m_q <= 32'(kh_q) * 32'(kw_q);
        OP_FAA_MUL2:  m_q <= m_q * 32'(cpg_q);
        OP_FAA_SET:   faa_q <= 22'(aln_f);
        OP_OAPR_MUL:  m_q <= 32'(ow_q) * 32'(fc_q);
        OP_OAPR_SET: begin
          oapr_q <= 28'(aln_a);
          w17_q  <= 5'((aln_a - m_q) >> 3);
        end
        OP_SRCH_INIT: begin
          lo_q <= 14'd1;
          hi_q <= ow_q + 14'd1;
        end
        OP_X_MID:     x_q <= 18'(kw_q) + 18'(mid - 14'd1) * 18'(sh_q);
        OP_X_WIN:     x_q <= 18'(kw_q) + 18'(win_q - 14'd1) * 18'(sh_q);
        OP_X_BLAST:   x_q <= 18'(kw_q) + 18'(blast_q - 14'd1) * 18'(sh_q);
        OP_P:         m_q <= 32'(ch_q) * 32'(x_q);
        OP_NEED:      need_q <= 27'(aln_a >> 4) + 27'd1;
        OP_EVAL: begin
          if (lo_q < hi_q) begin
            if (31'(need_q) * 31'(kh_q) > 31'd2048) hi_q <= mid;
            else lo_q <= mid + 14'd1;
          end
        end
        OP_WIN_FIX:   win_q <= win_fix;
        OP_BNUM_SET:  bnum_q <= 14'(div_q);
        OP_BLAST_MUL: m_q <= 32'(win_q) * 32'(bnum_q);
        OP_BLAST_SET: blast_q <= 14'(15'(ow_q) + 15'(win_q) - 15'(m_q));
        OP_NW_SAVE:   needw_q <= need_q;
        OP_W8_MUL:    m_q <= 32'(sh_q) * 32'(win_q);
        OP_W8_MUL2:   w8_q <= 31'(m_q * 32'(ch_q));
        OP_W18_SET: begin
          if (dz_q) w18_q <= 64'hFFFF_FFFF_FFFF_FFFE;
          else if (div_q == 32'd1024) w18_q <= 64'd1022;
          else w18_q <= 64'(div_q) - 64'd1;
        end
        OP_W19_SET: begin
          if (dz_q) w19_q <= 64'hFFFF_FFFF_FFFF_FFFD;
          else if (div_q > 32'd2) w19_q <= 64'(div_q) - 64'd2;
          else w19_q <= 64'd0;
        end
        OP_W20:       w20_q <= 27'(32'(fpg_al) * 32'(gc_q));
        OP_W5: begin
          w9_q <= ph_ch;
          w5_q <= iapr_q + 28'(ph_ch);
        end
        OP_W10: begin
          w10_q <= {{27{w10_p[36]}}, w10_p};
          w11_q <= 34'(iapr_q) * 34'({sv_q, 2'b00});
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.out_idx)
      W_OH:         word_sel = 64'(oh_q);
      W_OW:         word_sel = 64'(ow_q);
      W_FPG:        word_sel = 64'(fpg_q);
      W_CPG:        word_sel = 64'(cpg_q);
      W_IAPR:       word_sel = 64'(iapr_q);
      W_IPAD:       word_sel = 64'(w5_q);
      W_FAA:        word_sel = 64'(faa_q);
      W_OAPR:       word_sel = 64'(oapr_q);
      W_IBLK:       word_sel = 64'(w8_q);
      W_FPAD:       word_sel = 64'(w9_q);
      W_WFIRST:     word_sel = w10_q;
      W_WMULTI:     word_sel = 64'(w11_q);
      W_BNUM:       word_sel = 64'(bnum_q);
      W_BLEN:       word_sel = 64'(needw_q);
      W_BLEN_LAST:  word_sel = 64'(need_q);
      W_WIN:        word_sel = 64'(win_q);
      W_WIN_LAST:   word_sel = 64'(blast_q);
      W_RES_ALIGN:  word_sel = 64'(w17_q);
      W_PFULL:      word_sel = w18_q;
      W_POST_PFULL: word_sel = w19_q;
      W_BIAS_LEN:   word_sel = 64'(w20_q);
      W_CMD:        word_sel = {62'b0, 1'b1, relu_q};
      default:      word_sel = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      oidx_q  <= cmd_i.out_idx;
      oword_q <= cmd_i.out_err ? 64'd0 : word_sel;
      oerr_q  <= cmd_i.out_err;
      olast_q <= cmd_i.out_last;
    end
  end

  assign word_index_o = oidx_q;
  assign word_value_o = oword_q;
  assign error_o      = oerr_q;
  assign last_o       = olast_q;

  assign stat_o.err = (14'(kh_q) > 14'(ih_q) + {9'b0, pv_q, 1'b0}) ||
                      (14'(kw_q) > 14'(iw_q) + {9'b0, ph_q, 1'b0}) ||
                      (gc_q == 13'd0) || (ch_q < gc_q);
  assign stat_o.div_busy = div_busy;
  assign stat_o.div_done = div_done;
  assign stat_o.lo_lt_hi = lo_q < hi_q;

endmodule

`default_nettype wire

/* sv/cde_ctrl.sv */
// ----------------------------------------------------------------------------
// cde_ctrl
// Controller: input handshake, micro-program sequencing, output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module cde_ctrl
  import cde_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] pc_q, pc_d;
  logic [4:0] idx_q, idx_d;
  logic       err_q, err_d;
  logic       ovalid_q, ovalid_d;
  logic       last_beat;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = ovalid_q;
  assign last_beat   = err_q || (idx_q == W_CMD);

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    idx_d    = idx_q;
    err_d    = err_q;
    ovalid_d = ovalid_q;
    cmd_o          = '0;
    cmd_o.op       = PROG[pc_q];
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.out_idx  = err_q ? W_OH : idx_q;
    cmd_o.out_err  = err_q;
    cmd_o.out_last = last_beat;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        idx_d = '0;
        pc_d  = '0;
        err_d = stat_i.err;
        state_d = stat_i.err ? ST_EMIT : ST_RUN;
      end
      ST_RUN: begin
        cmd_o.exec = 1'b1;
        if (op_is_div(cmd_o.op)) begin
          state_d = ST_WAIT;
        end else if (cmd_o.op == OP_LOOP) begin
          pc_d = stat_i.lo_lt_hi ? LOOP_TARGET : pc_q + 6'd1;
        end else if (cmd_o.op == OP_END) begin
          state_d = ST_EMIT;
        end else begin
          pc_d = pc_q + 6'd1;
        end
      end
      ST_WAIT: begin
        if (stat_i.div_done) begin
          pc_d    = pc_q + 6'd1;
          state_d = ST_RUN;
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d = 1'b1;
          if (last_beat) state_d = ST_IDLE;
          else idx_d = idx_q + 5'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pc_q     <= '0;
      idx_q    <= '0;
      err_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      idx_q    <= idx_d;
      err_q    <= err_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |-> stat_i.div_busy)
    else $error("waiting on an idle divider");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_WAIT) |-> pc_q < 6'(PROG_LEN))
    else $error("program counter out of range");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && err_q) |-> idx_q == 5'd0)
    else $error("error layer emitting more than one beat");

endmodule

`default_nettype wire

/* sv/conv_descriptor_expander.sv */
// ----------------------------------------------------------------------------
// conv_descriptor_expander
// Expands one convolution layer description into 22 engine descriptor words.
//
//   channel  dir  handshake               beat content
//   in       in   in_valid_i/in_stall_o   one layer description
//   out      out  out_valid_o/out_stall_i word_index, word_value, error, last
//
// The first beat follows acceptance after the layer check, seven passes through
// the restoring divider and a window search of one to fourteen steps, each
// halving the search range. 22 beats follow, one a cycle when not stalled.
// An error layer gives a single beat, loaded in the emit state that follows
// the check state.
// Reset clears control only. Input is stalled from acceptance until the last
// beat is loaded; the output register waits on out_stall_i.
// ----------------------------------------------------------------------------
`default_nettype none

module conv_descriptor_expander
  import cde_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  kernel_width_i,
  input  wire logic [3:0]  kernel_height_i,
  input  wire logic [3:0]  stride_vertical_i,
  input  wire logic [3:0]  stride_horizontal_i,
  input  wire logic [12:0] channel_count_i,
  input  wire logic [12:0] image_height_i,
  input  wire logic [12:0] image_width_i,
  input  wire logic [3:0]  pad_vertical_i,
  input  wire logic [3:0]  pad_horizontal_i,
  input  wire logic [12:0] filter_count_i,
  input  wire logic [12:0] group_count_i,
  input  wire logic        relu_on_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       word_index_o,
  output logic [63:0]      word_value_o,
  output logic             error_o,
  output logic             last_o
);

  cmd_t  cmd;
  stat_t stat;

  cde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cde_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .kernel_width_i     (kernel_width_i),
    .kernel_height_i    (kernel_height_i),
    .stride_vertical_i  (stride_vertical_i),
    .stride_horizontal_i(stride_horizontal_i),
    .channel_count_i    (channel_count_i),
    .image_height_i     (image_height_i),
    .image_width_i      (image_width_i),
    .pad_vertical_i     (pad_vertical_i),
    .pad_horizontal_i   (pad_horizontal_i),
    .filter_count_i     (filter_count_i),
    .group_count_i      (group_count_i),
    .relu_on_i          (relu_on_i),
    .word_index_o       (word_index_o),
    .word_value_o       (word_value_o),
    .error_o            (error_o),
    .last_o             (last_o)
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable({word_index_o, word_value_o, error_o, last_o}))
    else $error("stalled beat changed");

  a_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second layer accepted while busy");

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && word_value_o == 64'd0)
    else $error("error beat not final or not zero");

endmodule

`default_nettype wire
